// ----- sv/fsnp_pkg.sv -----
package fsnp_pkg;

   // Widths and depths.
   localparam int POINTER_BITS_DEFAULT = 64;
   localparam int DIGIT_DEPTH = 20;
   localparam int CNT_W = 5;
   localparam int UPC_W = 4;

   // Division by ten as a multiplication by a scaled reciprocal.
   localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int DEC_SHIFT = 35;
   localparam int QUOT_W = 64 - DEC_SHIFT;

   // Item actions.
   localparam logic [1:0] ACT_FMT = 2'd0;
   localparam logic [1:0] ACT_ARG = 2'd1;
   localparam logic [1:0] ACT_STR = 2'd2;

   // Parse modes.
   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_PCT = 2'd1;
   localparam logic [1:0] MODE_ARG = 2'd2;
   localparam logic [1:0] MODE_STR = 2'd3;

   // Pending conversion kinds.
   localparam logic [2:0] KIND_C = 3'd0;
   localparam logic [2:0] KIND_D = 3'd1;
   localparam logic [2:0] KIND_U = 3'd2;
   localparam logic [2:0] KIND_XL = 3'd3;
   localparam logic [2:0] KIND_XU = 3'd4;
   localparam logic [2:0] KIND_P = 3'd5;

   // Characters.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_PCT = 8'h25;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UX = 8'h58;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LC = 8'h63;
   localparam logic [7:0] CH_LD = 8'h64;
   localparam logic [7:0] CH_LI = 8'h69;
   localparam logic [7:0] CH_LP = 8'h70;
   localparam logic [7:0] CH_LS = 8'h73;
   localparam logic [7:0] CH_LU = 8'h75;
   localparam logic [7:0] CH_LX = 8'h78;

   // Character sources of a control word.
   localparam logic [2:0] SRC_BYTE = 3'd0;
   localparam logic [2:0] SRC_MINUS = 3'd1;
   localparam logic [2:0] SRC_ZERO = 3'd2;
   localparam logic [2:0] SRC_X = 3'd3;
   localparam logic [2:0] SRC_DIGIT = 3'd4;

   // Datapath operations.
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_MUL = 3'd1;
   localparam logic [2:0] OP_DIV = 3'd2;
   localparam logic [2:0] OP_HEX = 3'd3;
   localparam logic [2:0] OP_POP = 3'd4;

   // Sequencing conditions.
   localparam logic [2:0] COND_NEXT = 3'd0;
   localparam logic [2:0] COND_GOTO = 3'd1;
   localparam logic [2:0] COND_WNZ = 3'd2;
   localparam logic [2:0] COND_CNZ = 3'd3;
   localparam logic [2:0] COND_DONE = 3'd4;

   // Microprogram addresses.
   localparam logic [UPC_W-1:0] A_EMIT = 4'd0;
   localparam logic [UPC_W-1:0] A_MINUS = 4'd1;
   localparam logic [UPC_W-1:0] A_DMUL = 4'd2;
   localparam logic [UPC_W-1:0] A_DDIV = 4'd3;
   localparam logic [UPC_W-1:0] A_POP = 4'd4;
   localparam logic [UPC_W-1:0] A_P0 = 4'd5;
   localparam logic [UPC_W-1:0] A_PX = 4'd6;
   localparam logic [UPC_W-1:0] A_HEX = 4'd7;
   localparam logic [UPC_W-1:0] A_HJMP = 4'd8;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] fmt_byte;
      logic [63:0] arg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic last_of_run;
   } rsp_type;

   typedef struct packed {
      logic emit;
      logic [2:0] src;
      logic last;
      logic [2:0] op;
      logic [2:0] cond;
      logic [UPC_W-1:0] target;
   } ctl_type;

   typedef struct packed {
      logic work_nz;
      logic cnt_last;
      logic [3:0] digit;
   } dp_status_type;

endpackage

// ----- sv/fsnp_ucode_rom.sv -----
module fsnp_ucode_rom (
   input logic [fsnp_pkg::UPC_W-1:0] upc,
   output fsnp_pkg::ctl_type ctl
);
   import fsnp_pkg::*;

   // Fields: emit, source, last, operation, condition, target.
   always_comb begin
      case (upc)
         A_EMIT: ctl = '{1'b1, SRC_BYTE, 1'b1, OP_NONE, COND_DONE, A_EMIT};
         A_MINUS: ctl = '{1'b1, SRC_MINUS, 1'b0, OP_NONE, COND_NEXT, A_DMUL};
         A_DMUL: ctl = '{1'b0, SRC_BYTE, 1'b0, OP_MUL, COND_NEXT, A_DDIV};
         A_DDIV: ctl = '{1'b0, SRC_BYTE, 1'b0, OP_DIV, COND_WNZ, A_DMUL};
         A_POP: ctl = '{1'b1, SRC_DIGIT, 1'b0, OP_POP, COND_CNZ, A_POP};
         A_P0: ctl = '{1'b1, SRC_ZERO, 1'b0, OP_NONE, COND_NEXT, A_PX};
         A_PX: ctl = '{1'b1, SRC_X, 1'b0, OP_NONE, COND_NEXT, A_HEX};
         A_HEX: ctl = '{1'b0, SRC_BYTE, 1'b0, OP_HEX, COND_WNZ, A_HEX};
         A_HJMP: ctl = '{1'b0, SRC_BYTE, 1'b0, OP_NONE, COND_GOTO, A_POP};
         default: ctl = '{1'b0, SRC_BYTE, 1'b0, OP_NONE, COND_DONE, A_EMIT};
      endcase
   end

endmodule

// ----- sv/fsnp_datapath.sv -----
module fsnp_datapath #(
   parameter int POINTER_BITS = fsnp_pkg::POINTER_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic load,
   input logic [POINTER_BITS-1:0] load_value,
   input logic step,
   input fsnp_pkg::ctl_type ctl,
   output fsnp_pkg::dp_status_type status
);
   import fsnp_pkg::*;

   logic [POINTER_BITS-1:0] work_ff, work_in;
   logic [63:0] prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0] digit_ff [DIGIT_DEPTH];
   logic [QUOT_W-1:0] quot;
   logic [QUOT_W+3:0] quot_x10;
   logic [3:0] rem;
   logic [3:0] new_digit;
   logic wr_en;
   logic [CNT_W-1:0] rd_idx;

   // Quotient and remainder by ten from the registered product.
   assign quot = prod_ff[63:DEC_SHIFT];
   assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
   assign rem = work_ff[3:0] - quot_x10[3:0];

   always_comb begin
      work_in = work_ff;
      prod_in = prod_ff;
      cnt_in = cnt_ff;
      wr_en = 1'b0;
      new_digit = work_ff[3:0];
      if (load) begin
         work_in = load_value;
         cnt_in = '0;
      end else if (step) begin
         case (ctl.op)
            OP_MUL: prod_in = 64'(work_ff[31:0]) * 64'(DEC_RECIP);
            OP_DIV: begin
               new_digit = rem;
               wr_en = 1'b1;
               work_in = POINTER_BITS'(quot);
               cnt_in = cnt_ff + 1'b1;
            end
            OP_HEX: begin
               wr_en = 1'b1;
               work_in = work_ff >> 4;
               cnt_in = cnt_ff + 1'b1;
            end
            OP_POP: cnt_in = cnt_ff - 1'b1;
            default: cnt_in = cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         cnt_ff <= '0;
      end else begin
         work_ff <= work_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (wr_en) begin
         digit_ff[cnt_ff] <= new_digit;
      end
   end

   assign rd_idx = cnt_ff - 1'b1;
   assign status.digit = (rd_idx < CNT_W'(DIGIT_DEPTH)) ? digit_ff[rd_idx] : 4'd0;
   assign status.work_nz = |work_in;
   assign status.cnt_last = (cnt_ff == CNT_W'(1));

endmodule

// ----- sv/format_string_number_printer_unit.sv -----
// Text, string and character items run only the emit step; its character is then
// registered in the output register. A decimal number runs a multiply and a divide step
// per digit, then a pop step per printed digit; hex runs a shift step per digit, a jump
// step, then the pop steps. A pointer prints 0 and x first, then runs the hex steps.
// One item is worked at a time; the next is taken as soon as its last character is stored.
// Synchronous active-high reset returns to plain text mode with no result pending.
module format_string_number_printer_unit #(
   parameter int POINTER_BITS = fsnp_pkg::POINTER_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input fsnp_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output fsnp_pkg::rsp_type rsp_data
);
   import fsnp_pkg::*;

   // Sequencer state. The block is busy while the microprogram runs.
   logic busy_ff, busy_in;
   logic [UPC_W-1:0] upc_ff, upc_in;
   logic [1:0] mode_ff, mode_in;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic upper_ff, upper_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic load;
   logic [POINTER_BITS-1:0] load_value;
   logic [31:0] arg_low;
   ctl_type ctl;
   dp_status_type status;
   logic out_free;
   logic step;
   logic emit_last;
   logic [7:0] digit_char;
   logic [7:0] emit_char;

   assign req_stall = busy_ff;
   assign accept = req_valid && !req_stall;
   assign arg_low = req_data.arg_value[31:0];

   // Dispatch: an accepted item updates the parse state and picks the entry point of
   // the microprogram. Items that print nothing never make the block busy.
   always_comb begin
      mode_in = mode_ff;
      kind_in = kind_ff;
      byte_in = byte_ff;
      upper_in = upper_ff;
      busy_in = busy_ff;
      upc_in = upc_ff;
      load = 1'b0;
      load_value = POINTER_BITS'(arg_low);
      if (accept) begin
         if (mode_ff == MODE_TEXT && req_data.action == ACT_FMT) begin
            if (req_data.fmt_byte == CH_PCT) begin
               mode_in = MODE_PCT;
            end else if (req_data.fmt_byte != CH_NUL) begin
               byte_in = req_data.fmt_byte;
               busy_in = 1'b1;
               upc_in = A_EMIT;
            end
         end else if (mode_ff == MODE_PCT && req_data.action == ACT_FMT) begin
            mode_in = MODE_ARG;
            case (req_data.fmt_byte)
               CH_LC: kind_in = KIND_C;
               CH_LD, CH_LI: kind_in = KIND_D;
               CH_LU: kind_in = KIND_U;
               CH_LX: kind_in = KIND_XL;
               CH_UX: kind_in = KIND_XU;
               CH_LP: kind_in = KIND_P;
               CH_LS: mode_in = MODE_STR;
               CH_NUL: begin
                  // A percent sign at the end of the format prints itself.
                  mode_in = MODE_TEXT;
                  byte_in = CH_PCT;
                  busy_in = 1'b1;
                  upc_in = A_EMIT;
               end
               default: begin
                  // Unknown specifier: the percent sign is dropped.
                  mode_in = MODE_TEXT;
                  byte_in = req_data.fmt_byte;
                  busy_in = 1'b1;
                  upc_in = A_EMIT;
               end
            endcase
         end else if (mode_ff == MODE_ARG && req_data.action == ACT_ARG) begin
            mode_in = MODE_TEXT;
            busy_in = 1'b1;
            load = 1'b1;
            case (kind_ff)
               KIND_C: begin
                  byte_in = arg_low[7:0];
                  upc_in = A_EMIT;
               end
               KIND_D: begin
                  // The negated minimum value still fits as an unsigned magnitude.
                  if (arg_low[31]) begin
                     load_value = POINTER_BITS'(32'd0 - arg_low);
                     upc_in = A_MINUS;
                  end else begin
                     upc_in = A_DMUL;
                  end
               end
               KIND_U: upc_in = A_DMUL;
               KIND_XL: begin
                  upper_in = 1'b0;
                  upc_in = A_HEX;
               end
               KIND_XU: begin
                  upper_in = 1'b1;
                  upc_in = A_HEX;
               end
               default: begin
                  load_value = req_data.arg_value[POINTER_BITS-1:0];
                  upper_in = 1'b0;
                  upc_in = A_P0;
               end
            endcase
         end else if (mode_ff == MODE_STR && req_data.action == ACT_STR) begin
            if (req_data.fmt_byte == CH_NUL) begin
               mode_in = MODE_TEXT;
            end else begin
               byte_in = req_data.fmt_byte;
               busy_in = 1'b1;
               upc_in = A_EMIT;
            end
         end
      end else if (step) begin
         // Sequencing of the running microprogram.
         case (ctl.cond)
            COND_NEXT: upc_in = upc_ff + 1'b1;
            COND_GOTO: upc_in = ctl.target;
            COND_WNZ: upc_in = status.work_nz ? ctl.target : upc_ff + 1'b1;
            COND_CNZ: begin
               if (status.cnt_last) begin
                  busy_in = 1'b0;
               end else begin
                  upc_in = ctl.target;
               end
            end
            COND_DONE: busy_in = 1'b0;
            default: busy_in = 1'b0;
         endcase
      end
   end

   fsnp_ucode_rom u_rom (
      .upc(upc_ff),
      .ctl(ctl)
   );

   // A step that prints waits until the output register can take its character.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step = busy_ff && (!ctl.emit || out_free);

   fsnp_datapath #(
      .POINTER_BITS(POINTER_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .load(load),
      .load_value(load_value),
      .step(step),
      .ctl(ctl),
      .status(status)
   );

   always_comb begin
      if (status.digit < 4'd10) begin
         digit_char = CH_ZERO + {4'd0, status.digit};
      end else begin
         digit_char = (upper_ff ? CH_UA : CH_LA) + {4'd0, status.digit} - 8'd10;
      end
   end

   always_comb begin
      case (ctl.src)
         SRC_BYTE: emit_char = byte_ff;
         SRC_MINUS: emit_char = CH_MINUS;
         SRC_ZERO: emit_char = CH_ZERO;
         SRC_X: emit_char = CH_LX;
         SRC_DIGIT: emit_char = digit_char;
         default: emit_char = byte_ff;
      endcase
   end

   // The last printed digit closes the run; other steps carry their own flag.
   assign emit_last = (ctl.op == OP_POP) ? status.cnt_last : ctl.last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (step && ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.out_char = emit_char;
         rsp_data_in.last_of_run = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff <= A_EMIT;
         mode_ff <= MODE_TEXT;
         kind_ff <= KIND_C;
         upper_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         upc_ff <= upc_in;
         mode_ff <= mode_in;
         kind_ff <= kind_in;
         upper_ff <= upper_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The microprogram counter stays inside the program while it runs.
   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> upc_ff <= A_HJMP)
      else $error("microprogram counter left the program");

   // Finishing an item always leaves its closing character in the output register.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff && rsp_data_ff.last_of_run)
      else $error("item finished without a closing character");

   // A closing character ends the microprogram.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      step && ctl.emit && emit_last |=> !busy_ff)
      else $error("microprogram kept running after the closing character");

   // New results only come from a running microprogram.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result produced while idle");

endmodule
